>>> design/dwmp_pkg.sv
// Package for the depth-weighted micro price block: default widths, result status
// codes and configuration register indexes.
// No dependencies; used by the channel interfaces and the top level.
package dwmp_pkg;

  // Default field widths.
  localparam int unsigned PRICE_BITS_DEF       = 32;
  localparam int unsigned QUANTITY_BITS_DEF    = 32;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 16;

  // Fraction bits of the result and width of the weighted volume sums.
  localparam int unsigned OUT_FRAC = 16;
  localparam int unsigned SUM_BITS = 64;

  // Result status codes.
  localparam logic [1:0] STATUS_WEIGHTED = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_MIDPOINT = 2'd2;

  // Configuration port layout: registers lie at byte address 4*index.
  localparam int unsigned CFG_ADDR_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam logic [0:0]  REG_DECAY_RATIO = 1'b0;

endpackage

>>> design/dwmp_in_if.sv
// Input channel of the depth-weighted micro price block: at most one book level per item.
// Depends on dwmp_pkg for the default widths.
interface dwmp_in_if #(
  parameter int unsigned PRICE_BITS    = dwmp_pkg::PRICE_BITS_DEF,
  parameter int unsigned QUANTITY_BITS = dwmp_pkg::QUANTITY_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic                     carries_level;
  logic                     side;
  logic [PRICE_BITS-1:0]    level_price;
  logic [QUANTITY_BITS-1:0] level_quantity;
  logic                     last;

  modport source (
    output valid, carries_level, side, level_price, level_quantity, last,
    input  ready
  );

  modport sink (
    input  valid, carries_level, side, level_price, level_quantity, last,
    output ready
  );
endinterface

>>> design/dwmp_out_if.sv
// Result channel of the depth-weighted micro price block: one price per snapshot.
// Depends on dwmp_pkg for the default widths and the output fraction bits.
interface dwmp_out_if #(
  parameter int unsigned PRICE_BITS = dwmp_pkg::PRICE_BITS_DEF
);
  logic                                     valid;
  logic                                     ready;
  logic [PRICE_BITS+dwmp_pkg::OUT_FRAC-1:0] micro_price;
  logic [1:0]                               status;

  modport source (
    output valid, micro_price, status,
    input  ready
  );

  modport sink (
    input  valid, micro_price, status,
    output ready
  );
endinterface

>>> design/depth_weighted_micro_price_core.sv
// Top level of the depth-weighted micro price block: level accumulation, final
// multiply and divide, result register and the configuration port.
// Depends on dwmp_pkg, dwmp_in_if and dwmp_out_if.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------------------
//   in_chan  | in        | valid/ready             | carries_level side price qty last
//   out_chan | out       | valid/ready             | micro_price status
//   cfg      | in/out    | APB write, pready high  | decay_ratio at byte address 0
//
// A level item takes the accept and three steps: quantity times weight in the shared
// multiplier, the accumulate in the 65-bit adder with weight times ratio, the weight
// update. The item marked last then runs the empty side check, the total, the spread
// (in the other order too when the ask is below the bid), a shift-add multiply and a
// restoring divide, one bit a cycle, both on the shared adder. An empty side skips to
// the result load; a zero total takes the midpoint step. Reset is synchronous; no
// clearing pass. A full result register holds back the next result; no items are taken meanwhile.
module depth_weighted_micro_price_core #(
  parameter int unsigned PRICE_BITS       = dwmp_pkg::PRICE_BITS_DEF,
  parameter int unsigned QUANTITY_BITS    = dwmp_pkg::QUANTITY_BITS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = dwmp_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dwmp_in_if.sink                              in_chan,
  dwmp_out_if.source                           out_chan,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [dwmp_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [dwmp_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [dwmp_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  localparam int unsigned WB    = WEIGHT_FRAC_BITS + 1;
  localparam int unsigned AW    = (QUANTITY_BITS > WB) ? QUANTITY_BITS : WB;
  localparam int unsigned PW    = AW + WB;
  localparam int unsigned EXT   = (PW > dwmp_pkg::SUM_BITS) ? PW : dwmp_pkg::SUM_BITS;
  localparam int unsigned SB    = dwmp_pkg::SUM_BITS;
  localparam int unsigned DW    = PRICE_BITS + dwmp_pkg::OUT_FRAC;
  localparam int unsigned CNT_W = $clog2(DW);
  localparam logic [WB-1:0] WEIGHT_ONE = WB'(1) << WEIGHT_FRAC_BITS;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MULQ  = 12'b0000_0000_0010,
    S_ACC   = 12'b0000_0000_0100,
    S_WUPD  = 12'b0000_0000_1000,
    S_CHK   = 12'b0000_0001_0000,
    S_TOT   = 12'b0000_0010_0000,
    S_DIFF  = 12'b0000_0100_0000,
    S_DIFF2 = 12'b0000_1000_0000,
    S_MID   = 12'b0001_0000_0000,
    S_MUL   = 12'b0010_0000_0000,
    S_DIV   = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_t;

  // Control and snapshot state (reset).
  state_t                  state_r, state_nxt;
  logic [WB-1:0]           ratio_r, ratio_nxt;
  logic [WB-1:0]           bw_r, bw_nxt, aw_r, aw_nxt;
  logic [SB-1:0]           bv_r, bv_nxt, av_r, av_nxt;
  logic [PRICE_BITS-1:0]   bp_r, bp_nxt, ap_r, ap_nxt;
  logic                    bseen_r, bseen_nxt, aseen_r, aseen_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Working and payload registers (no reset).
  logic                     side_r, side_nxt;
  logic                     last_r, last_nxt;
  logic [PRICE_BITS-1:0]    price_r, price_nxt;
  logic [QUANTITY_BITS-1:0] qty_r, qty_nxt;
  logic [PW-1:0]            prod_r, prod_nxt;
  logic [SB-1:0]            ph_r, ph_nxt, tot_r, tot_nxt;
  logic [DW-1:0]            pl_r, pl_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     use_ask_r, use_ask_nxt;
  logic [1:0]               fin_status_r, fin_status_nxt;
  logic [DW-1:0]            out_price_r, out_price_nxt;
  logic [1:0]               out_status_r, out_status_nxt;

  // Shared unit signals.
  logic [AW-1:0]           mul_a;
  logic [WB-1:0]           mul_b;
  logic [PW-1:0]           mul_p;
  logic [SB:0]             add_a, add_b;
  logic                    add_sub;
  logic [SB+1:0]           add_res;
  logic                    add_ge;

  logic [WB-1:0]           w_sel;
  logic [SB-1:0]           vol_sel, mul_sel;
  logic [PRICE_BITS-1:0]   base_sel;
  logic [EXT-1:0]          prod_x;
  logic                    prod_ovf;
  logic                    out_free;
  logic                    in_take;
  logic                    cfg_wr;
  logic [WB-1:0]           wr_val;
  logic                    cnt_end;

  // Per-side selections.
  assign w_sel    = side_r ? aw_r : bw_r;
  assign vol_sel  = side_r ? av_r : bv_r;
  assign mul_sel  = use_ask_r ? av_r : bv_r;
  assign base_sel = use_ask_r ? ap_r : bp_r;
  assign cnt_end  = (cnt_r == CNT_W'(DW - 1));

  // Saturation of the weighted quantity at the sum width.
  assign prod_x   = EXT'(prod_r);
  assign prod_ovf = |(prod_x >> SB);

  // Handshakes.
  assign in_chan.ready     = (state_r == S_IDLE);
  assign in_take           = in_chan.valid && in_chan.ready;
  assign out_free          = !out_valid_r || out_chan.ready;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.micro_price = out_price_r;
  assign out_chan.status      = out_status_r;

  // Configuration port: writes saturate the ratio at 1.0.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite &&
                  (paddr[dwmp_pkg::CFG_ADDR_BITS-1:2] == dwmp_pkg::REG_DECAY_RATIO);
  assign wr_val = pwdata[WB-1:0];
  assign prdata = (paddr[dwmp_pkg::CFG_ADDR_BITS-1:2] == dwmp_pkg::REG_DECAY_RATIO) ?
                  dwmp_pkg::CFG_DATA_BITS'(ratio_r) : '0;
  assign ratio_nxt = cfg_wr ? ((wr_val > WEIGHT_ONE) ? WEIGHT_ONE : wr_val) : ratio_r;

  // Shared multiplier: quantity times weight, or weight times ratio.
  always_comb begin
    if (state_r == S_MULQ) begin
      mul_a = AW'(qty_r);
      mul_b = w_sel;
    end else begin
      mul_a = AW'(w_sel);
      mul_b = ratio_r;
    end
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Shared adder and subtractor; add_ge is the no-borrow flag of a subtract.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_ACC: begin
        add_a = {1'b0, vol_sel};
        add_b = {1'b0, prod_x[SB-1:0]};
      end
      S_CHK, S_TOT: begin
        add_a = {1'b0, bv_r};
        add_b = {1'b0, av_r};
      end
      S_DIFF: begin
        add_a   = (SB+1)'(ap_r);
        add_b   = (SB+1)'(bp_r);
        add_sub = 1'b1;
      end
      S_DIFF2: begin
        add_a   = (SB+1)'(bp_r);
        add_b   = (SB+1)'(ap_r);
        add_sub = 1'b1;
      end
      S_MID: begin
        add_a = (SB+1)'(bp_r);
        add_b = (SB+1)'(ap_r);
      end
      S_MUL: begin
        add_a = {1'b0, ph_r};
        add_b = pl_r[0] ? {1'b0, mul_sel} : '0;
      end
      S_DIV: begin
        add_a   = {ph_r, pl_r[DW-1]};
        add_b   = {1'b0, tot_r};
        add_sub = 1'b1;
      end
      S_OUT: begin
        add_a = (fin_status_r == dwmp_pkg::STATUS_WEIGHTED) ?
                (SB+1)'({base_sel, {dwmp_pkg::OUT_FRAC{1'b0}}}) : '0;
        add_b = (SB+1)'(pl_r);
      end
      default: begin
        add_a = '0;
      end
    endcase
    add_res = {1'b0, add_a} + ({1'b0, add_b} ^ {(SB+2){add_sub}}) + (SB+2)'(add_sub);
    add_ge  = ~add_res[SB+1];
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    bw_nxt         = bw_r;
    aw_nxt         = aw_r;
    bv_nxt         = bv_r;
    av_nxt         = av_r;
    bp_nxt         = bp_r;
    ap_nxt         = ap_r;
    bseen_nxt      = bseen_r;
    aseen_nxt      = aseen_r;
    side_nxt       = side_r;
    last_nxt       = last_r;
    price_nxt      = price_r;
    qty_nxt        = qty_r;
    prod_nxt       = prod_r;
    ph_nxt         = ph_r;
    pl_nxt         = pl_r;
    tot_nxt        = tot_r;
    cnt_nxt        = cnt_r;
    use_ask_nxt    = use_ask_r;
    fin_status_nxt = fin_status_r;
    out_price_nxt  = out_price_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_chan.ready ? 1'b0 : out_valid_r;

    case (state_r)
      // Take an item; a bare marker with last goes straight to the final check, else it is dropped.
      S_IDLE: begin
        if (in_take) begin
          side_nxt  = in_chan.side;
          last_nxt  = in_chan.last;
          price_nxt = in_chan.level_price;
          qty_nxt   = in_chan.level_quantity;
          if (in_chan.carries_level) begin
            state_nxt = S_MULQ;
          end else if (in_chan.last) begin
            state_nxt = S_CHK;
          end
        end
      end
      // Quantity times current weight.
      S_MULQ: begin
        prod_nxt  = mul_p;
        state_nxt = S_ACC;
      end
      // Saturating accumulate, best price, and weight times ratio.
      S_ACC: begin
        prod_nxt = mul_p;
        if (side_r) begin
          av_nxt = (add_res[SB] || prod_ovf) ? '1 : add_res[SB-1:0];
          if (!aseen_r) begin
            aseen_nxt = 1'b1;
            ap_nxt    = price_r;
          end
        end else begin
          bv_nxt = (add_res[SB] || prod_ovf) ? '1 : add_res[SB-1:0];
          if (!bseen_r) begin
            bseen_nxt = 1'b1;
            bp_nxt    = price_r;
          end
        end
        state_nxt = S_WUPD;
      end
      // Truncated weight update.
      S_WUPD: begin
        if (side_r) begin
          aw_nxt = WB'(prod_r >> WEIGHT_FRAC_BITS);
        end else begin
          bw_nxt = WB'(prod_r >> WEIGHT_FRAC_BITS);
        end
        state_nxt = last_r ? S_CHK : S_IDLE;
      end
      // Empty side check, and halving when the total would overflow.
      S_CHK: begin
        if (!bseen_r || !aseen_r) begin
          fin_status_nxt = dwmp_pkg::STATUS_EMPTY;
          pl_nxt         = '0;
          state_nxt      = S_OUT;
        end else begin
          if (add_res[SB]) begin
            bv_nxt = bv_r >> 1;
            av_nxt = av_r >> 1;
          end
          state_nxt = S_TOT;
        end
      end
      // Total volume; zero total gives the midpoint.
      S_TOT: begin
        tot_nxt   = add_res[SB-1:0];
        state_nxt = (add_res[SB-1:0] == '0) ? S_MID : S_DIFF;
      end
      S_MID: begin
        pl_nxt         = {add_res[PRICE_BITS:0], {(dwmp_pkg::OUT_FRAC-1){1'b0}}};
        fin_status_nxt = dwmp_pkg::STATUS_MIDPOINT;
        state_nxt      = S_OUT;
      end
      // Price spread against the lower price; the other order when ask is below bid.
      S_DIFF: begin
        if (add_ge) begin
          use_ask_nxt = 1'b0;
          pl_nxt      = {add_res[PRICE_BITS-1:0], {dwmp_pkg::OUT_FRAC{1'b0}}};
          ph_nxt      = '0;
          cnt_nxt     = '0;
          state_nxt   = S_MUL;
        end else begin
          state_nxt = S_DIFF2;
        end
      end
      S_DIFF2: begin
        use_ask_nxt = 1'b1;
        pl_nxt      = {add_res[PRICE_BITS-1:0], {dwmp_pkg::OUT_FRAC{1'b0}}};
        ph_nxt      = '0;
        cnt_nxt     = '0;
        state_nxt   = S_MUL;
      end
      // Shift-add multiply, one spread bit a cycle, LSB first.
      S_MUL: begin
        ph_nxt  = add_res[SB:1];
        pl_nxt  = {add_res[0], pl_r[DW-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_end) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      // Restoring divide; quotient bits shift into the low half.
      S_DIV: begin
        ph_nxt  = add_ge ? add_res[SB-1:0] : {ph_r[SB-2:0], pl_r[DW-1]};
        pl_nxt  = {pl_r[DW-2:0], add_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_end) begin
          fin_status_nxt = dwmp_pkg::STATUS_WEIGHTED;
          state_nxt      = S_OUT;
        end
      end
      // Load the result register and clear the snapshot.
      S_OUT: begin
        if (out_free) begin
          out_price_nxt  = add_res[DW-1:0];
          out_status_nxt = fin_status_r;
          out_valid_nxt  = 1'b1;
          bw_nxt         = WEIGHT_ONE;
          aw_nxt         = WEIGHT_ONE;
          bv_nxt         = '0;
          av_nxt         = '0;
          bp_nxt         = '0;
          ap_nxt         = '0;
          bseen_nxt      = 1'b0;
          aseen_nxt      = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and snapshot registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ratio_r     <= WEIGHT_ONE;
      bw_r        <= WEIGHT_ONE;
      aw_r        <= WEIGHT_ONE;
      bv_r        <= '0;
      av_r        <= '0;
      bp_r        <= '0;
      ap_r        <= '0;
      bseen_r     <= 1'b0;
      aseen_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ratio_r     <= ratio_nxt;
      bw_r        <= bw_nxt;
      aw_r        <= aw_nxt;
      bv_r        <= bv_nxt;
      av_r        <= av_nxt;
      bp_r        <= bp_nxt;
      ap_r        <= ap_nxt;
      bseen_r     <= bseen_nxt;
      aseen_r     <= aseen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    side_r       <= side_nxt;
    last_r       <= last_nxt;
    price_r      <= price_nxt;
    qty_r        <= qty_nxt;
    prod_r       <= prod_nxt;
    ph_r         <= ph_nxt;
    pl_r         <= pl_nxt;
    tot_r        <= tot_nxt;
    cnt_r        <= cnt_nxt;
    use_ask_r    <= use_ask_nxt;
    fin_status_r <= fin_status_nxt;
    out_price_r  <= out_price_nxt;
    out_status_r <= out_status_nxt;
  end

`ifndef SYNTHESIS
  // Weights never grow past 1.0.
  a_weight_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (bw_r <= WEIGHT_ONE) && (aw_r <= WEIGHT_ONE))
    else $error("side weight above 1.0");

  // The stored ratio is saturated.
  a_ratio_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ratio_r <= WEIGHT_ONE)
    else $error("decay ratio above 1.0");

  // The divide remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (ph_r < tot_r))
    else $error("divide remainder not below total");

  // Multiply and divide only run with a nonzero total.
  a_tot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_MUL) || (state_r == S_DIV)) |-> (tot_r != '0))
    else $error("divide entered with zero total");

  // A result appears only from the result load step.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result valid without result load");
`endif

endmodule

>>> tb/sv/depth_weighted_micro_price_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for depth_weighted_micro_price_core: book levels in, micro price out.
// Depends on dwmp_pkg, dwmp_in_if, dwmp_out_if and the core; keeps its own model of the book.
module depth_weighted_micro_price_core_test;

  localparam int unsigned PRICE_W  = dwmp_pkg::PRICE_BITS_DEF;
  localparam int unsigned QTY_W    = dwmp_pkg::QUANTITY_BITS_DEF;
  localparam int unsigned FRAC_W   = dwmp_pkg::WEIGHT_FRAC_BITS_DEF;
  localparam int unsigned QUOTE_W  = PRICE_W + dwmp_pkg::OUT_FRAC;
  localparam int unsigned CFG_AW   = dwmp_pkg::CFG_ADDR_BITS;
  localparam logic [FRAC_W:0] WEIGHT_ONE = (FRAC_W + 1)'(1) << FRAC_W;
  localparam logic SIDE_BID = 1'b0;
  localparam logic SIDE_ASK = 1'b1;
  // Register index past the end of the register list; writes there must be ignored.
  localparam int unsigned REG_SPARE      = 1;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned QUOTE_CYCLES   = 2 * QUOTE_W + 16;
  localparam int unsigned RX_HOLD_CYCLES = 700;
  localparam int unsigned ITEMS_RANDOM   = 350;
  localparam int unsigned CYCLE_LIMIT    = 500_000;

  typedef struct packed {
    logic              carries_level;
    logic              side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic              last;
  } book_item_t;

  typedef struct packed {
    logic [QUOTE_W-1:0] price;
    logic [1:0]         status;
  } quote_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                psel, penable, pwrite, pready;
  logic [CFG_AW-1:0]   paddr;
  logic [dwmp_pkg::CFG_DATA_BITS-1:0] pwdata, prdata;

  dwmp_in_if  in_if ();
  dwmp_out_if out_if ();

  depth_weighted_micro_price_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Book model: decay ratio plus per-side weight, weighted volume, best price and seen flag.
  logic [FRAC_W:0]    decay_ratio_q;
  logic [FRAC_W:0]    side_weight [2];
  logic [63:0]        side_volume [2];
  logic [PRICE_W-1:0] side_best [2];
  bit                 side_seen [2];

  quote_t      quote_q [$];
  int unsigned fail_count = 0;
  int unsigned book_items = 0;
  int unsigned cycle_count = 0;
  bit          idle_en = 1'b1;
  bit          rx_hold = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic void book_clear();
    for (int s = 0; s < 2; s++) begin
      side_weight[s] = WEIGHT_ONE;
      side_volume[s] = '0;
      side_best[s]   = '0;
      side_seen[s]   = 1'b0;
    end
  endfunction

  // Micro price of the collected book, truncated to Q32.16.
  function automatic quote_t book_quote();
    quote_t             q;
    logic [63:0]        vb, va, full;
    logic [64:0]        total;
    logic [PRICE_W:0]   px_sum;
    logic [PRICE_W-1:0] spread, base;
    logic [127:0]       num, quo;
    vb = side_volume[SIDE_BID];
    va = side_volume[SIDE_ASK];
    if (!side_seen[SIDE_BID] || !side_seen[SIDE_ASK]) begin
      q.price  = '0;
      q.status = dwmp_pkg::STATUS_EMPTY;
      return q;
    end
    total = {1'b0, vb} + {1'b0, va};
    // A total that does not fit 64 bits halves both volumes.
    if (total[64]) begin
      vb    = vb >> 1;
      va    = va >> 1;
      total = {1'b0, vb} + {1'b0, va};
    end
    if (total == 0) begin
      px_sum   = {1'b0, side_best[SIDE_BID]} + {1'b0, side_best[SIDE_ASK]};
      q.price  = {px_sum, {(dwmp_pkg::OUT_FRAC - 1){1'b0}}};
      q.status = dwmp_pkg::STATUS_MIDPOINT;
      return q;
    end
    if (side_best[SIDE_ASK] >= side_best[SIDE_BID]) begin
      spread = side_best[SIDE_ASK] - side_best[SIDE_BID];
      base   = side_best[SIDE_BID];
      num    = 128'(vb) * 128'({spread, {dwmp_pkg::OUT_FRAC{1'b0}}});
    end else begin
      spread = side_best[SIDE_BID] - side_best[SIDE_ASK];
      base   = side_best[SIDE_ASK];
      num    = 128'(va) * 128'({spread, {dwmp_pkg::OUT_FRAC{1'b0}}});
    end
    quo      = num / 128'(total);
    full     = 64'({base, {dwmp_pkg::OUT_FRAC{1'b0}}}) + quo[63:0];
    q.price  = full[QUOTE_W-1:0];
    q.status = dwmp_pkg::STATUS_WEIGHTED;
    return q;
  endfunction

  // Apply one accepted item to the book; a last item closes it and yields a quote.
  function automatic void book_take(input book_item_t it);
    logic [63:0]         prod;
    logic [64:0]         sum;
    logic [2*FRAC_W+1:0] next_w;
    if (it.carries_level) begin
      if (!side_seen[it.side]) begin
        side_seen[it.side] = 1'b1;
        side_best[it.side] = it.price;
      end
      prod = 64'(it.qty) * 64'(side_weight[it.side]);
      sum  = {1'b0, side_volume[it.side]} + {1'b0, prod};
      side_volume[it.side] = sum[64] ? '1 : sum[63:0];
      next_w = (2*FRAC_W + 2)'(side_weight[it.side]) * (2*FRAC_W + 2)'(decay_ratio_q);
      side_weight[it.side] = next_w[2*FRAC_W:FRAC_W];
    end
    if (it.last) begin
      quote_q.push_back(book_quote());
      book_clear();
    end
  endfunction

  function automatic book_item_t make_level(input logic side, input logic [PRICE_W-1:0] price,
                                            input logic [QTY_W-1:0] qty, input logic last);
    book_item_t it;
    it.carries_level = 1'b1;
    it.side          = side;
    it.price         = price;
    it.qty           = qty;
    it.last          = last;
    return it;
  endfunction

  // Bare marker with random filler in the level fields.
  function automatic book_item_t make_marker(input logic last);
    book_item_t it;
    it.carries_level = 1'b0;
    it.side          = 1'($urandom_range(0, 1));
    it.price         = $urandom;
    it.qty           = $urandom;
    it.last          = last;
    return it;
  endfunction

  function automatic logic [QTY_W-1:0] pick_qty();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return $urandom;
      2:       return '1;
      default: return $urandom_range(1, 5000);
    endcase
  endfunction

  function automatic logic [31:0] pick_ratio();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'(WEIGHT_ONE);
      2:       return $urandom_range(0, 65536);
      3:       return $urandom;
      4:       return $urandom_range(60000, 65535);
      default: return ($urandom << (FRAC_W + 1)) | $urandom_range(0, 65536);
    endcase
  endfunction

  // Send one item: random idle cycles first, then hold it until the core takes it.
  task automatic send_item(input book_item_t it);
    while (idle_en && $urandom_range(0, 99) < 38) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.carries_level  <= it.carries_level;
    in_if.side           <= it.side;
    in_if.level_price    <= it.price;
    in_if.level_quantity <= it.qty;
    in_if.last           <= it.last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    book_take(it);
    if (it.carries_level || it.last) book_items++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every quote is back and the core has settled.
  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (quote_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup, access, then idle; the ratio is read back.
  task automatic cfg_write(input int unsigned index, input logic [31:0] value);
    logic [FRAC_W:0] v;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'(index << 2);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (index == dwmp_pkg::REG_DECAY_RATIO) begin
      v = value[FRAC_W:0];
      decay_ratio_q = (v > WEIGHT_ONE) ? WEIGHT_ONE : v;
    end
    @(negedge clk);
    if (index == dwmp_pkg::REG_DECAY_RATIO && prdata !== 32'(decay_ratio_q))
      note_failure($sformatf("ratio readback mismatch: expected %h, got %h",
                             32'(decay_ratio_q), prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_idling(input bit on);
    @(posedge clk);
    idle_en = on;
    @(negedge clk);
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold = 1'b0;
  endtask

  // Result side: random stalls, or a long hold-off when asked.
  always @(negedge clk) begin
    if (rx_hold) out_if.ready <= 1'b0;
    else out_if.ready <= !(idle_en && $urandom_range(0, 99) < 38);
  end

  // Compare each quote with the oldest one predicted.
  always @(posedge clk) begin
    quote_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (quote_q.size() == 0) begin
        note_failure($sformatf("unexpected quote: price %h status %0d",
                               out_if.micro_price, out_if.status));
      end else begin
        want = quote_q.pop_front();
        if (out_if.micro_price !== want.price || out_if.status !== want.status)
          note_failure($sformatf("quote mismatch: expected price %h status %0d, got %h %0d",
                                 want.price, want.status, out_if.micro_price, out_if.status));
      end
    end
  end

  // Two-sided book at the reset ratio of 1.0.
  task automatic test_basic_book();
    send_item(make_level(SIDE_BID, 32'd1000, 32'd10, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd1004, 32'd30, 1'b0));
    send_item(make_level(SIDE_BID, 32'd999, 32'd5, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd1005, 32'd7, 1'b1));
    wait_drain();
  endtask

  // Empty sides, zero volume, crossed book at the field extremes, zero spread.
  task automatic test_special_books();
    send_item(make_marker(1'b1));
    send_item(make_level(SIDE_BID, 32'd50, 32'd3, 1'b0));
    send_item(make_marker(1'b1));
    send_item(make_level(SIDE_BID, 32'd77, 32'd0, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd80, 32'd0, 1'b1));
    send_item(make_level(SIDE_BID, '1, '1, 1'b0));
    send_item(make_marker(1'b0));
    send_item(make_level(SIDE_ASK, '0, '1, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd5, 32'd1, 1'b1));
    send_item(make_level(SIDE_ASK, '0, 32'd1, 1'b0));
    send_item(make_level(SIDE_BID, '0, '1, 1'b1));
    wait_drain();
  endtask

  // Ratio of zero, saturation above 1.0, ignored upper bits and spare index,
  // and a ratio change in the middle of a book.
  task automatic test_ratio_settings();
    cfg_write(dwmp_pkg::REG_DECAY_RATIO, 32'd0);
    send_item(make_level(SIDE_BID, 32'd10, 32'd100, 1'b0));
    send_item(make_level(SIDE_BID, 32'd9, 32'd100, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd12, 32'd50, 1'b1));
    wait_drain();
    cfg_write(dwmp_pkg::REG_DECAY_RATIO, 32'h0001_FFFF);
    cfg_write(REG_SPARE, 32'h0000_4000);
    send_item(make_level(SIDE_BID, 32'd200, '1, 1'b0));
    send_item(make_level(SIDE_BID, 32'd199, 32'd7, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd201, 32'd9, 1'b1));
    wait_drain();
    cfg_write(dwmp_pkg::REG_DECAY_RATIO, 32'hFFFE_8000);
    send_item(make_level(SIDE_BID, 32'd100, 32'd64, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd104, 32'd64, 1'b0));
    wait_drain();
    cfg_write(dwmp_pkg::REG_DECAY_RATIO, 32'h0000_4000);
    send_item(make_level(SIDE_BID, 32'd99, 32'd64, 1'b0));
    send_item(make_level(SIDE_ASK, 32'd105, 32'd64, 1'b1));
    wait_drain();
    cfg_write(dwmp_pkg::REG_DECAY_RATIO, 32'(WEIGHT_ONE));
  endtask

  // Hold the result side off while short books keep coming, so the core stalls its input.
  task automatic test_back_pressure();
    fork
      hold_receiver(RX_HOLD_CYCLES);
    join_none
    for (int i = 0; i < 12; i++) begin
      send_item(make_level(SIDE_BID, 32'd5000 - i, $urandom_range(1, 100), 1'b0));
      send_item(make_level(SIDE_ASK, 32'd5003 + i, $urandom_range(1, 100), 1'b1));
    end
    wait_drain();
  endtask

  // One random book: mostly well-ordered levels, sometimes noise and crossed prices.
  task automatic send_random_book();
    int unsigned        n_bid, n_ask, i_bid, i_ask;
    bit                 noisy, last_on_level, pick_ask, closing;
    logic [PRICE_W-1:0] bid_px, ask_px;
    noisy  = ($urandom_range(0, 9) == 0);
    n_bid  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    n_ask  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    bid_px = $urandom_range(0, 1) ? $urandom : $urandom_range(100, 200000);
    ask_px = noisy ? $urandom : bid_px + $urandom_range(1, 40);
    last_on_level = $urandom_range(0, 1) && (n_bid + n_ask != 0);
    i_bid = 0;
    i_ask = 0;
    while (i_bid < n_bid || i_ask < n_ask) begin
      pick_ask = (i_bid == n_bid) || (i_ask < n_ask && $urandom_range(0, 1));
      closing  = (i_bid + i_ask + 1 == n_bid + n_ask) && last_on_level;
      if (noisy && $urandom_range(0, 3) == 0) send_item(make_marker(1'b0));
      if (pick_ask) begin
        send_item(make_level(SIDE_ASK, ask_px, pick_qty(), closing));
        ask_px = noisy ? $urandom : ask_px + $urandom_range(0, 5);
        i_ask++;
      end else begin
        send_item(make_level(SIDE_BID, bid_px, pick_qty(), closing));
        bid_px = noisy ? $urandom : bid_px - $urandom_range(0, 5);
        i_bid++;
      end
    end
    if (!last_on_level) send_item(make_marker(1'b1));
  endtask

  // Random books with a new ratio every few books and a stretch without idling.
  task automatic test_random_books();
    int unsigned start, books;
    start = book_items;
    books = 0;
    while (book_items - start < ITEMS_RANDOM) begin
      if (books % 6 == 5) begin
        wait_drain();
        if ($urandom_range(0, 3) == 0) cfg_write(REG_SPARE, $urandom);
        cfg_write(dwmp_pkg::REG_DECAY_RATIO, pick_ratio());
        set_idling(!(books >= 18 && books < 36));
      end
      send_random_book();
      books++;
    end
    wait_drain();
    set_idling(1'b1);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_if.valid          = 1'b0;
    in_if.carries_level  = 1'b0;
    in_if.side           = 1'b0;
    in_if.level_price    = '0;
    in_if.level_quantity = '0;
    in_if.last           = 1'b0;
    out_if.ready         = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    decay_ratio_q        = WEIGHT_ONE;
    book_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_book();
    test_special_books();
    test_ratio_settings();
    test_back_pressure();
    test_random_books();

    wait_drain();
    repeat (QUOTE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
